>>> hw/rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types and codes for the memory region registry: opcodes, status
// codes, the command broadcast to the cells and the link between cells.
// ----------------------------------------------------------------------------
package mrr_pkg;

    localparam int ADDR_W   = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND       = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXISTS    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RESOLVE
    } state_t;

    // request held for the whole operation; qend is address + span, 65 bits
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W:0]   qend;
    } cmd_t;

    // priority link passed from cell to cell
    typedef struct packed {
        logic              sel_seen;
        logic [SLOT_W-1:0] sel_slot;
        logic [ADDR_W-1:0] sel_base;
        logic [ADDR_W-1:0] sel_length;
        logic              free_seen;
        logic [SLOT_W-1:0] free_slot;
    } link_t;

    // commit controls broadcast to all cells
    typedef struct packed {
        logic eval;
        logic do_reg;
        logic do_unreg;
    } ctrl_t;

endpackage

>>> hw/rtl/mrr_cell.sv
// ----------------------------------------------------------------------------
// mrr_cell
// One table slot: valid bit, base, length and end address. Evaluates the
// request against its slot, then joins the priority link to its neighbor.
// ----------------------------------------------------------------------------
module mrr_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mrr_pkg::cmd_t  cmd,
    input  mrr_pkg::ctrl_t ctrl,
    input  mrr_pkg::link_t link_in,
    output mrr_pkg::link_t link_out
);
    import mrr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [ADDR_W:0]   end_reg;
    logic              sel_reg;
    logic              sel_next;
    logic              free_reg;
    logic              free_next;
    logic              win_sel;
    logic              win_free;
    logic              write_en;
    logic [SLOT_W-1:0] my_slot;

    assign my_slot  = SLOT_W'(CELL_IDX);
    assign win_sel  = sel_reg && !link_in.sel_seen;
    assign win_free = free_reg && !link_in.free_seen;
    assign write_en = ctrl.do_reg && win_free;

    always_comb
    begin
        sel_next  = sel_reg;
        free_next = free_reg;
        if (ctrl.eval)
        begin
            free_next = !valid_reg;
            if (cmd.op == OP_FIND)
                sel_next = valid_reg && (cmd.address >= base_reg) && (cmd.qend <= end_reg);
            else
                sel_next = valid_reg && (base_reg == cmd.address);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (write_en)
            valid_next = 1'b1;
        else if (ctrl.do_unreg && win_sel)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            base_reg <= cmd.address;
            len_reg  <= cmd.span;
            end_reg  <= cmd.qend;
        end
    end

    always_comb
    begin
        link_out = link_in;
        if (win_sel)
        begin
            link_out.sel_seen   = 1'b1;
            link_out.sel_slot   = my_slot;
            link_out.sel_base   = base_reg;
            link_out.sel_length = len_reg;
        end
        if (win_free)
        begin
            link_out.free_seen = 1'b1;
            link_out.free_slot = my_slot;
        end
    end

endmodule

>>> hw/rtl/memory_region_registry_top.sv
// ----------------------------------------------------------------------------
// memory_region_registry_top
// Table of memory regions built as a row of slot cells with register,
// unregister and find-containing-region requests.
//
//  channel   ports                               handshake
//  request   opcode, address, span               start & !busy
//  result    status, slot, found_base,           done, one cycle
//            found_length
//
// one request at a time: capture, evaluation in all cells, then the
// priority link through the row of cells and the commit to the winning cell
// busy is high from acceptance until the result is resolved; done comes with busy low
// the result shows for one cycle and cannot be held off by the receiver
// reset clears all slot valid bits at once; no clearing pass
// ----------------------------------------------------------------------------
module memory_region_registry_top #(
    parameter int REGION_SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mrr_pkg::OP_W-1:0]      opcode,
    input  logic [mrr_pkg::ADDR_W-1:0]    address,
    input  logic [mrr_pkg::ADDR_W-1:0]    span,
    output logic                          done,
    output logic [mrr_pkg::STATUS_W-1:0]  status,
    output logic [mrr_pkg::SLOT_W-1:0]    slot,
    output logic [mrr_pkg::ADDR_W-1:0]    found_base,
    output logic [mrr_pkg::ADDR_W-1:0]    found_length
);
    import mrr_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    cmd_t              cmd_reg;
    logic              arg_bad_reg;
    ctrl_t             ctrl;
    link_t             link [0:REGION_SLOTS];
    link_t             tail;
    logic              accept;
    logic              done_reg;
    logic              done_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [ADDR_W-1:0] fbase_reg;
    logic [ADDR_W-1:0] fbase_next;
    logic [ADDR_W-1:0] flen_reg;
    logic [ADDR_W-1:0] flen_next;

    assign accept  = start && !busy;
    assign link[0] = '0;
    assign tail    = link[REGION_SLOTS];

    genvar g;
    generate
        for (g = 0; g < REGION_SLOTS; g++)
        begin : g_cell
            mrr_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd_reg),
                .ctrl     (ctrl),
                .link_in  (link[g]),
                .link_out (link[g+1])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (start) state_next = ST_EVAL;
            ST_EVAL:    state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy          = 1'b1;
        ctrl          = '0;
        done_next     = 1'b0;
        status_next   = STATUS_INVALID;
        slot_next     = '0;
        fbase_next    = '0;
        flen_next     = '0;
        case (state_reg)
            ST_IDLE:
                busy = 1'b0;
            ST_EVAL:
                ctrl.eval = 1'b1;
            ST_RESOLVE:
            begin
                done_next = 1'b1;
                case (cmd_reg.op)
                    OP_REGISTER:
                    begin
                        if (arg_bad_reg)
                            status_next = STATUS_INVALID;
                        else if (tail.sel_seen)
                            status_next = STATUS_EXISTS;
                        else if (tail.free_seen)
                        begin
                            status_next = STATUS_OK;
                            slot_next   = tail.free_slot;
                            ctrl.do_reg = 1'b1;
                        end
                        else
                            status_next = STATUS_FULL;
                    end
                    OP_UNREGISTER:
                    begin
                        if (tail.sel_seen)
                        begin
                            status_next   = STATUS_OK;
                            slot_next     = tail.sel_slot;
                            ctrl.do_unreg = 1'b1;
                        end
                        else
                            status_next = STATUS_NOT_FOUND;
                    end
                    OP_FIND:
                    begin
                        if (tail.sel_seen)
                        begin
                            status_next = STATUS_OK;
                            slot_next   = tail.sel_slot;
                            fbase_next  = tail.sel_base;
                            flen_next   = tail.sel_length;
                        end
                        else
                            status_next = STATUS_NOT_FOUND;
                    end
                    default:
                        status_next = STATUS_INVALID;
                endcase
            end
            default:
                busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.op      <= opcode;
            cmd_reg.address <= address;
            cmd_reg.span    <= span;
            cmd_reg.qend    <= {1'b0, address} + {1'b0, span};
            arg_bad_reg     <= (address == '0) || (span == '0);
        end
        status_reg <= status_next;
        slot_reg   <= slot_next;
        fbase_reg  <= fbase_next;
        flen_reg   <= flen_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign found_base   = fbase_reg;
    assign found_length = flen_reg;

endmodule
